// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and character helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int RSP_DEPTH = 4;   // result queue entries, power of two, >= 2

   typedef enum logic [2:0] {
      PH_LEAD = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_U0   = 3'd3,
      PH_U1   = 3'd4,
      PH_U2   = 3'd5,
      PH_U3   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_SYNTAX = 2'd2,
      KIND_UNIMPL = 2'd3
   } kind_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;      // results caused by this beat, 0..2
      result_type res0;
      result_type res1;
      phase_type  phase;
      logic [3:0] nibble;
   } decode_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic [7:0] lc;
      lc = c | 8'h20;
      return (c >= CH_ZERO && c <= CH_NINE) || (lc >= CH_LA && lc <= CH_LF_HEX);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= CH_NINE) begin
         v = c - CH_ZERO;
      end else begin
         v = (c | 8'h20) - CH_LA + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

// ===== rtl/json_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes one JSON string from a byte stream, one raw byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req      | in        | req_valid / req_ready | req_in_byte, req_in_last
//  rsp      | out       | rsp_valid / rsp_ready | rsp_out_byte, rsp_out_kind, rsp_out_last
//
//  One raw byte per cycle while the queue has room; a byte passes through
//  the input register, then is decoded into the result queue, from which
//  its results leave as output beats.
//  A byte that causes two results gives them on separate output beats; the queue
//  absorbs this so input keeps flowing while results drain.
//  Reset returns to the leading-whitespace phase and empties both stages.
//  Input stalls only when the queue lacks room for two results.
// ----------------------------------------------------------------------------
module json_string_unescaper #(
   parameter int RSP_DEPTH = jsu_pkg::RSP_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind,
   output logic       rsp_out_last
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   jsu_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         nibble_ff, nibble_in;
   jsu_pkg::decode_type dec;
   jsu_pkg::result_type out_res;
   logic               room;
   logic               advance;
   logic [1:0]         push_count;

   assign advance    = in_valid_ff && room;
   assign req_ready  = !in_valid_ff || advance;
   assign push_count = advance ? dec.count : 2'd0;

   jsu_decode u_decode (
      .phase   (phase_ff),
      .nibble  (nibble_ff),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .dec     (dec)
   );

   jsu_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (dec.res0),
      .push1      (dec.res1),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_res    (out_res)
   );

   assign rsp_out_byte = out_res.data;
   assign rsp_out_kind = out_res.kind;
   assign rsp_out_last = out_res.last;

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      phase_in    = advance ? dec.phase : phase_ff;
      nibble_in   = advance ? dec.nibble : nibble_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= jsu_pkg::PH_LEAD;
         nibble_ff   <= 4'h0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         nibble_ff   <= nibble_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   // ---- assertions ----
   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind != jsu_pkg::KIND_BYTE) |-> rsp_out_byte == 8'h00)
      else $error("status result carries nonzero byte");

   a_end_to_lead: assert property (@(posedge clock) disable iff (reset)
      advance && (dec.count != 2'd0) && (dec.res0.kind != jsu_pkg::KIND_BYTE)
      |=> phase_ff == jsu_pkg::PH_LEAD)
      else $error("phase not back to leading after completion or error");

   a_pair_tail: assert property (@(posedge clock) disable iff (reset)
      advance && (dec.count == 2'd2)
      |-> !dec.res0.last && dec.res1.last && (dec.res1.kind == jsu_pkg::KIND_SYNTAX))
      else $error("two-result beat not ended by syntax error");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> phase_ff == jsu_pkg::PH_LEAD)
      else $error("phase left open after final input byte");

endmodule

// ===== rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Per-byte phase update and result generation (up to two results per byte).
// ----------------------------------------------------------------------------
module jsu_decode (
   input  jsu_pkg::phase_type  phase,
   input  logic [3:0]          nibble,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output jsu_pkg::decode_type dec
);

   jsu_pkg::phase_type ph_n;
   logic [3:0]         nib_n;
   logic               has0;
   jsu_pkg::kind_type  k0;
   logic [7:0]         b0;
   logic               ended;
   logic               tail;
   jsu_pkg::result_type r0;
   jsu_pkg::result_type rt;

   always_comb begin
      ph_n  = phase;
      nib_n = nibble;
      has0  = 1'b0;
      k0    = jsu_pkg::KIND_BYTE;
      b0    = 8'h00;
      ended = 1'b0;
      case (phase)
         jsu_pkg::PH_BODY: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               has0  = 1'b1;
               k0    = jsu_pkg::KIND_DONE;
               ended = 1'b1;
            end else if (in_byte == jsu_pkg::CH_BSLASH) begin
               ph_n = jsu_pkg::PH_ESC;
            end else begin
               has0 = 1'b1;
               b0   = in_byte;
            end
         end
         jsu_pkg::PH_ESC: begin
            has0 = 1'b1;
            ph_n = jsu_pkg::PH_BODY;
            case (in_byte)
               jsu_pkg::CH_U: begin
                  has0 = 1'b0;
                  ph_n = jsu_pkg::PH_U0;
               end
               jsu_pkg::CH_QUOTE:  b0 = jsu_pkg::CH_QUOTE;
               jsu_pkg::CH_BSLASH: b0 = jsu_pkg::CH_BSLASH;
               jsu_pkg::CH_SLASH:  b0 = jsu_pkg::CH_SLASH;
               8'h62:              b0 = 8'h08;   // b
               8'h66:              b0 = 8'h0C;   // f
               8'h6E:              b0 = 8'h0A;   // n
               8'h72:              b0 = 8'h0D;   // r
               8'h74:              b0 = 8'h09;   // t
               default: begin
                  k0    = jsu_pkg::KIND_SYNTAX;
                  ended = 1'b1;
               end
            endcase
         end
         jsu_pkg::PH_U0, jsu_pkg::PH_U1: begin
            if (in_byte == jsu_pkg::CH_ZERO) begin
               ph_n = (phase == jsu_pkg::PH_U0) ? jsu_pkg::PH_U1 : jsu_pkg::PH_U2;
            end else begin
               has0  = 1'b1;
               k0    = jsu_pkg::KIND_UNIMPL;
               ended = 1'b1;
            end
         end
         jsu_pkg::PH_U2: begin
            if (jsu_pkg::is_hex(in_byte)) begin
               nib_n = jsu_pkg::hex_value(in_byte);
               ph_n  = jsu_pkg::PH_U3;
            end else begin
               has0  = 1'b1;
               k0    = jsu_pkg::KIND_SYNTAX;
               ended = 1'b1;
            end
         end
         jsu_pkg::PH_U3: begin
            has0 = 1'b1;
            if (jsu_pkg::is_hex(in_byte)) begin
               b0   = {nibble, jsu_pkg::hex_value(in_byte)};
               ph_n = jsu_pkg::PH_BODY;
            end else begin
               k0    = jsu_pkg::KIND_SYNTAX;
               ended = 1'b1;
            end
         end
         default: begin
            // leading phase; unused code 7 behaves the same
            if (in_byte == jsu_pkg::CH_SPACE || in_byte == jsu_pkg::CH_TAB ||
                in_byte == jsu_pkg::CH_NL || in_byte == jsu_pkg::CH_CR) begin
               if (in_last) begin
                  has0  = 1'b1;
                  k0    = jsu_pkg::KIND_SYNTAX;
                  ended = 1'b1;
               end
            end else if (in_byte == jsu_pkg::CH_QUOTE) begin
               ph_n = jsu_pkg::PH_BODY;
            end else begin
               has0  = 1'b1;
               k0    = jsu_pkg::KIND_SYNTAX;
               ended = 1'b1;
            end
         end
      endcase

      // input ran out while still inside the string
      tail = !ended && in_last && (ph_n != jsu_pkg::PH_LEAD);
      if (ended || tail) begin
         ph_n  = jsu_pkg::PH_LEAD;
         nib_n = 4'h0;
      end

      r0.data = b0;
      r0.kind = k0;
      r0.last = !tail;
      rt.data = 8'h00;
      rt.kind = jsu_pkg::KIND_SYNTAX;
      rt.last = 1'b1;

      dec.count  = {1'b0, has0} + {1'b0, tail};
      dec.res0   = has0 ? r0 : rt;
      dec.res1   = rt;
      dec.phase  = ph_n;
      dec.nibble = nib_n;
   end

endmodule

// ===== rtl/jsu_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// jsu_rsp_fifo
// Result queue: takes zero, one or two results per cycle, gives one per beat.
// ----------------------------------------------------------------------------
module jsu_rsp_fifo #(
   parameter int DEPTH = jsu_pkg::RSP_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  jsu_pkg::result_type push0,
   input  jsu_pkg::result_type push1,
   output logic                room,       // space for two more results
   output logic                out_valid,
   input  logic                out_ready,
   output jsu_pkg::result_type out_res
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   jsu_pkg::result_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;
   logic          pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[rd_ptr_ff];
   assign room      = (count_ff <= CW'(DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

endmodule
